[hdl/fwds_pkg.sv]
package fwds_pkg;

  // item field widths
  localparam int unsigned POS_W      = 17;
  localparam int unsigned WT_W       = 17;
  localparam int unsigned CONTRIB_W  = 49;
  localparam int unsigned TOTAL_W    = 63;

  // stream word widths
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 112;

  // tree entry widths
  localparam int unsigned SUM_W      = 33;
  localparam int unsigned CNT_W      = 17;
  localparam int unsigned EPOCH_W    = 8;

  // shared multiplier and distance datapath
  localparam int unsigned MUL_W      = 19;
  localparam int unsigned PROD_W     = 2 * MUL_W;
  localparam int unsigned DSUM_W     = PROD_W + 1;
  localparam int unsigned DIST_W     = 35;
  localparam int unsigned LO_W       = 18;
  localparam int unsigned LO_PW      = WT_W + LO_W;
  localparam int unsigned HI_PW      = WT_W + DIST_W - LO_W;
  localparam int unsigned FULL_W     = WT_W + DIST_W;

  localparam logic [EPOCH_W-1:0] EPOCH_MAX = '1;

  typedef struct packed {
    logic [EPOCH_W-1:0] epoch;
    logic [SUM_W-1:0]   sum;
    logic [CNT_W-1:0]   cnt;
  } fwds_entry_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_QRY,
    ST_MUL_C,
    ST_DIST,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_SUM,
    ST_ACC,
    ST_UPD,
    ST_FIN
  } fwds_state_t;

endpackage

[hdl/fwds_mul.sv]
module fwds_mul import fwds_pkg::*; (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [MUL_W-1:0]  a,
  input  logic signed [MUL_W-1:0]  b,
  output logic signed [PROD_W-1:0] prod_r
);

  // signed multiply, product registered
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= a * b;
    end
  end

endmodule

[hdl/fenwick_weighted_distance_sum_top.sv]
// per word: prefix walk, count-difference product, distance, two weight partial products,
//   contribution clip, running total, insert walk, then the result goes to the output register
// one word at a time: the next word is taken only once the last result is in the result
//   register, which waits while that register is still full; the tree walks set the rate
// reset (rst_n low, synchronous) clears control, totals and the epoch, then a clearing
//   pass zeroes all POSITION_COUNT + 1 entries of the tree ram; the same pass runs once every
//   256 start_new words when the epoch tag wraps
module fenwick_weighted_distance_sum_top import fwds_pkg::*; #(
  parameter int unsigned POSITION_COUNT = 65536
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // in_tdata: position [16:0], weight [33:17], zero pad [39:34]
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // in_tuser: start_new [0]
  input  logic [0:0]            in_tuser,
  // out_tdata: contribution [48:0], running_total [111:49]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  // out_tuser: saturated [0]
  output logic [0:0]            out_tuser
);

  // tree index widths: entries 1..POSITION_COUNT, the update walk may step past the end
  localparam int unsigned IW = $clog2(POSITION_COUNT + 1);
  localparam int unsigned UW = IW + 1;
  localparam int unsigned CW = (IW > POS_W) ? IW : POS_W;
  localparam logic [CW-1:0] LIMIT_C = CW'(POSITION_COUNT);
  localparam logic [UW-1:0] LIMIT_U = UW'(POSITION_COUNT);
  localparam logic [IW-1:0] LAST_I  = IW'(POSITION_COUNT);

  // both fenwick trees share one ram: each entry holds the position sum, the count and
  // an epoch tag; an entry whose tag differs from the current epoch reads as zero, so a
  // start_new bumps the epoch and sweeps the ram only when the tag wraps
  fwds_entry_t tree_mem [0:POSITION_COUNT];

  fwds_state_t state_r, state_nxt;

  logic [EPOCH_W-1:0] epoch_r, epoch_nxt;
  logic [IW-1:0]      clr_idx_r, clr_idx_nxt;
  logic               pend_r, pend_nxt;

  logic [POS_W-1:0]   p_r, p_nxt;
  logic [WT_W-1:0]    w_r, w_nxt;
  logic [UW-1:0]      idx_r, idx_nxt;
  logic               rdv_r, rdv_nxt;
  logic [IW-1:0]      wr_idx_r, wr_idx_nxt;

  logic [SUM_W-1:0]   s_le_r, s_le_nxt;
  logic [CNT_W-1:0]   c_le_r, c_le_nxt;
  logic [SUM_W-1:0]   s_all_r, s_all_nxt;
  logic [CNT_W-1:0]   c_all_r, c_all_nxt;

  logic [DIST_W-1:0]    dist_r, dist_nxt;
  logic [LO_PW-1:0]     lo_r, lo_nxt;
  logic [CONTRIB_W-1:0] contrib_r, contrib_nxt;
  logic [TOTAL_W-1:0]   total_r, total_nxt;
  logic                 sat_r, sat_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic                  out_sat_r, out_sat_nxt;

  // tree ram ports
  logic        rd_en;
  logic [IW-1:0] rd_addr;
  fwds_entry_t rd_data_r;
  logic        wr_en;
  logic [IW-1:0] wr_addr;
  fwds_entry_t wr_data;

  // shared multiplier
  logic                     mul_en;
  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] mul_p;

  // datapath helpers
  logic               rd_hit;
  logic [SUM_W-1:0]   rd_sum;
  logic [CNT_W-1:0]   rd_cnt;
  logic [POS_W-1:0]   in_pos;
  logic [CW-1:0]      in_pos_ext;
  logic [POS_W-1:0]   pos_clamp;
  logic [SUM_W-1:0]   s_hi;
  logic [CNT_W-1:0]   c_hi;
  logic [CNT_W:0]     c_diff;
  logic signed [DSUM_W-1:0] dsum;
  logic [FULL_W-1:0]  full_prod;
  logic [TOTAL_W:0]   tsum;

  fwds_mul u_mul (
    .clk    (clk),
    .en     (mul_en),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (mul_p)
  );

  // stale entries (older epoch) count as empty
  assign rd_hit = (rd_data_r.epoch == epoch_r);
  assign rd_sum = rd_hit ? rd_data_r.sum : '0;
  assign rd_cnt = rd_hit ? rd_data_r.cnt : '0;

  // position clamp: zero reads as one, anything past the depth as the last position
  assign in_pos     = in_tdata[POS_W-1:0];
  assign in_pos_ext = CW'(in_pos);
  always_comb begin
    priority if (in_pos == '0) begin
      pos_clamp = POS_W'(1);
    end else if (in_pos_ext > LIMIT_C) begin
      pos_clamp = LIMIT_C[POS_W-1:0];
    end else begin
      pos_clamp = in_pos;
    end
  end

  // upper halves come from the running totals minus the prefix up to p
  assign s_hi   = s_all_r - s_le_r;
  assign c_hi   = c_all_r - c_le_r;
  assign c_diff = {1'b0, c_le_r} - {1'b0, c_hi};

  // distance = s_hi - s_le + (c_le - c_hi) * p
  assign dsum = DSUM_W'(mul_p) + $signed(DSUM_W'(s_hi)) - $signed(DSUM_W'(s_le_r));

  // weight times distance, from two partial products
  assign full_prod = {mul_p[HI_PW-1:0], LO_W'(0)} + FULL_W'(lo_r);

  assign tsum = {1'b0, total_r} + (TOTAL_W + 1)'(contrib_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      epoch_r     <= '0;
      clr_idx_r   <= '0;
      pend_r      <= 1'b0;
      rdv_r       <= 1'b0;
      s_all_r     <= '0;
      c_all_r     <= '0;
      total_r     <= '0;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      epoch_r     <= epoch_nxt;
      clr_idx_r   <= clr_idx_nxt;
      pend_r      <= pend_nxt;
      rdv_r       <= rdv_nxt;
      s_all_r     <= s_all_nxt;
      c_all_r     <= c_all_nxt;
      total_r     <= total_nxt;
      sat_r       <= sat_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r        <= p_nxt;
    w_r        <= w_nxt;
    idx_r      <= idx_nxt;
    wr_idx_r   <= wr_idx_nxt;
    s_le_r     <= s_le_nxt;
    c_le_r     <= c_le_nxt;
    dist_r     <= dist_nxt;
    lo_r       <= lo_nxt;
    contrib_r  <= contrib_nxt;
    out_data_r <= out_data_nxt;
    out_sat_r  <= out_sat_nxt;
  end

  // tree ram: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      tree_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= tree_mem[rd_addr];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    epoch_nxt     = epoch_r;
    clr_idx_nxt   = clr_idx_r;
    pend_nxt      = pend_r;
    p_nxt         = p_r;
    w_nxt         = w_r;
    idx_nxt       = idx_r;
    rdv_nxt       = rdv_r;
    wr_idx_nxt    = wr_idx_r;
    s_le_nxt      = s_le_r;
    c_le_nxt      = c_le_r;
    s_all_nxt     = s_all_r;
    c_all_nxt     = c_all_r;
    dist_nxt      = dist_r;
    lo_nxt        = lo_r;
    contrib_nxt   = contrib_r;
    total_nxt     = total_r;
    sat_nxt       = sat_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    out_data_nxt  = out_data_r;
    out_sat_nxt   = out_sat_r;

    in_tready = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = idx_r[IW-1:0];
    wr_en     = 1'b0;
    wr_addr   = wr_idx_r;
    wr_data   = '{epoch: epoch_r, sum: rd_sum + SUM_W'(p_r), cnt: rd_cnt + CNT_W'(1)};
    mul_en    = 1'b0;
    mul_a     = $signed(MUL_W'(dist_r[LO_W-1:0]));
    mul_b     = $signed(MUL_W'(w_r));

    unique case (state_r)
      // sweep the whole ram with empty entries of the current epoch
      ST_CLEAR: begin
        wr_en       = 1'b1;
        wr_addr     = clr_idx_r;
        wr_data     = '{epoch: epoch_r, sum: '0, cnt: '0};
        clr_idx_nxt = clr_idx_r + IW'(1);
        if (clr_idx_r == LAST_I) begin
          clr_idx_nxt = '0;
          pend_nxt    = 1'b0;
          state_nxt   = pend_r ? ST_QRY : ST_IDLE;
        end
      end

      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          p_nxt    = pos_clamp;
          w_nxt    = in_tdata[POS_W +: WT_W];
          idx_nxt  = UW'(pos_clamp);
          rdv_nxt  = 1'b0;
          s_le_nxt = '0;
          c_le_nxt = '0;
          state_nxt = ST_QRY;
          if (in_tuser[0]) begin
            total_nxt = '0;
            sat_nxt   = 1'b0;
            s_all_nxt = '0;
            c_all_nxt = '0;
            // new set: fresh epoch, or a full sweep when the tag wraps
            if (epoch_r == EPOCH_MAX) begin
              epoch_nxt = '0;
              pend_nxt  = 1'b1;
              state_nxt = ST_CLEAR;
            end else begin
              epoch_nxt = epoch_r + EPOCH_W'(1);
            end
          end
        end
      end

      // prefix walk down from p, reads pipelined one ahead of the accumulate
      ST_QRY: begin
        if (rdv_r) begin
          s_le_nxt = s_le_r + rd_sum;
          c_le_nxt = c_le_r + rd_cnt;
        end
        if (idx_r != '0) begin
          rd_en   = 1'b1;
          idx_nxt = idx_r & (idx_r - UW'(1));
          rdv_nxt = 1'b1;
        end else begin
          rdv_nxt   = 1'b0;
          state_nxt = ST_MUL_C;
        end
      end

      ST_MUL_C: begin
        mul_en    = 1'b1;
        mul_a     = MUL_W'($signed(c_diff));
        mul_b     = $signed(MUL_W'(p_r));
        state_nxt = ST_DIST;
      end

      // a negative distance (only after wrapped sums) clamps to zero
      ST_DIST: begin
        dist_nxt  = dsum[DSUM_W-1] ? '0 : dsum[DIST_W-1:0];
        state_nxt = ST_MUL_LO;
      end

      ST_MUL_LO: begin
        mul_en    = 1'b1;
        mul_a     = $signed(MUL_W'(dist_r[LO_W-1:0]));
        state_nxt = ST_MUL_HI;
      end

      ST_MUL_HI: begin
        mul_en    = 1'b1;
        mul_a     = $signed(MUL_W'(dist_r[DIST_W-1:LO_W]));
        lo_nxt    = mul_p[LO_PW-1:0];
        state_nxt = ST_SUM;
      end

      ST_SUM: begin
        contrib_nxt = (|full_prod[FULL_W-1:CONTRIB_W]) ? '1 : full_prod[CONTRIB_W-1:0];
        state_nxt   = ST_ACC;
      end

      // running total with clip, then set up the insert walk
      ST_ACC: begin
        if (tsum[TOTAL_W]) begin
          total_nxt = '1;
          sat_nxt   = 1'b1;
        end else begin
          total_nxt = tsum[TOTAL_W-1:0];
        end
        s_all_nxt = s_all_r + SUM_W'(p_r);
        c_all_nxt = c_all_r + CNT_W'(1);
        idx_nxt   = UW'(p_r);
        rdv_nxt   = 1'b0;
        state_nxt = ST_UPD;
      end

      // insert walk up from p: read one node while writing back the previous one
      ST_UPD: begin
        wr_en = rdv_r;
        if (idx_r <= LIMIT_U) begin
          rd_en      = 1'b1;
          wr_idx_nxt = idx_r[IW-1:0];
          idx_nxt    = idx_r + (idx_r & (~idx_r + UW'(1)));
          rdv_nxt    = 1'b1;
        end else begin
          rdv_nxt   = 1'b0;
          state_nxt = ST_FIN;
        end
      end

      // hand the result to the output register once it is free
      ST_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {total_r, contrib_r};
          out_sat_nxt   = sat_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_sat_r;

endmodule

[hdl/fwds_chk.sv]
module fwds_chk import fwds_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [0:0]            out_tuser
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // one word at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted on back-to-back cycles");

  // clip flag only with the total pinned at its maximum
  a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> (out_tdata[OUT_DATA_W-1:CONTRIB_W] == '1))
    else $error("saturated flag without full-scale total");

  // reset leaves no result and runs the clearing pass
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !in_tready)
    else $error("outputs active after reset");

endmodule

bind fenwick_weighted_distance_sum_top fwds_chk u_fwds_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

[verif/testbench.sv]
module testbench import fwds_pkg::*;;

  localparam int unsigned POS_COUNT    = 65536;
  localparam int unsigned ITEM_TARGET  = 1750;
  localparam int unsigned SINGLE_SETS  = 260;    // enough one-word sets to wrap the epoch tag
  localparam int unsigned HOLD_AT      = 500;    // results seen before the long receiver hold
  localparam int unsigned HOLD_CYCLES  = 800;
  localparam int unsigned MID_DRAIN_AT = 1100;   // words sent before the mid-run drain pause
  localparam int unsigned DRAIN_SLACK  = 80;
  localparam int unsigned CYCLE_LIMIT  = 3000000;

  localparam longint unsigned CONTRIB_CAP = (64'd1 << CONTRIB_W) - 64'd1;

  // one input word as the block sees it
  typedef struct packed {
    logic [POS_W-1:0] position;
    logic [WT_W-1:0]  weight;
    logic             start_new;
  } item_t;

  // one result word
  typedef struct packed {
    logic [CONTRIB_W-1:0] contribution;
    logic [TOTAL_W-1:0]   running_total;
    logic                 saturated;
  } tally_t;

  // directed stimulus row; typed rows carry a hand-written expected tally
  typedef struct packed {
    item_t  item;
    logic   typed;
    tally_t tally;
  } row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [0:0]            in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [0:0]            out_tuser;

  tally_t      pending_tallies [$];
  row_t        directed_rows [$];
  int unsigned words_sent = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  bit          steady = 1'b0;     // both sides run without gaps while set

  // predictor state: sparse fenwick trees, missing entries read as zero
  logic [SUM_W-1:0]   dist_sum_tree [int unsigned];
  logic [CNT_W-1:0]   hit_count_tree [int unsigned];
  logic [TOTAL_W-1:0] model_total = '0;
  logic               model_clipped = 1'b0;

  fenwick_weighted_distance_sum_top #(
    .POSITION_COUNT(POS_COUNT)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic logic [SUM_W-1:0] sum_prefix(int unsigned upto);
    logic [SUM_W-1:0] acc;
    int unsigned i;
    acc = '0;
    i = upto;
    while (i > 0) begin
      if (dist_sum_tree.exists(i)) acc = acc + dist_sum_tree[i];
      i = i - (i & (~i + 1));
    end
    return acc;
  endfunction

  function automatic logic [CNT_W-1:0] count_prefix(int unsigned upto);
    logic [CNT_W-1:0] acc;
    int unsigned i;
    acc = '0;
    i = upto;
    while (i > 0) begin
      if (hit_count_tree.exists(i)) acc = acc + hit_count_tree[i];
      i = i - (i & (~i + 1));
    end
    return acc;
  endfunction

  // folds one accepted word into the predictor and returns its tally
  function automatic tally_t fold_in_item(item_t it);
    int unsigned       p;
    int unsigned       i;
    logic [SUM_W-1:0]  s_le, s_hi;
    logic [CNT_W-1:0]  c_le, c_hi;
    logic [TOTAL_W-1:0] headroom;
    longint            dist_acc;
    longint unsigned   contrib;
    tally_t            t;
    if (it.start_new) begin
      dist_sum_tree.delete();
      hit_count_tree.delete();
      model_total = '0;
      model_clipped = 1'b0;
    end
    // out-of-range positions clamp to the ends of the tree
    p = 32'(it.position);
    if (p == 0) p = 1;
    if (p > POS_COUNT) p = POS_COUNT;
    s_le = sum_prefix(p);
    c_le = count_prefix(p);
    s_hi = sum_prefix(POS_COUNT) - s_le;
    c_hi = count_prefix(POS_COUNT) - c_le;
    // distance to the positions above minus none, plus to those at or below
    dist_acc = longint'(s_hi) - longint'(c_hi) * longint'(p)
             + longint'(c_le) * longint'(p) - longint'(s_le);
    if (dist_acc < 0) dist_acc = 0;
    contrib = dist_acc * longint'(it.weight);
    if (contrib > CONTRIB_CAP) contrib = CONTRIB_CAP;
    headroom = {TOTAL_W{1'b1}} - model_total;
    if (contrib > headroom) begin
      model_total = {TOTAL_W{1'b1}};
      model_clipped = 1'b1;
    end else begin
      model_total = model_total + contrib[TOTAL_W-1:0];
    end
    i = p;
    while (i >= 1 && i <= POS_COUNT) begin
      dist_sum_tree[i] = (dist_sum_tree.exists(i) ? dist_sum_tree[i] : '0) + SUM_W'(p);
      hit_count_tree[i] = (hit_count_tree.exists(i) ? hit_count_tree[i] : '0) + CNT_W'(1);
      i = i + (i & (~i + 1));
    end
    t.contribution = contrib[CONTRIB_W-1:0];
    t.running_total = model_total;
    t.saturated = model_clipped;
    return t;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // mostly short gaps, now and then a long one
  function automatic int unsigned pause_len();
    int unsigned roll;
    roll = $urandom_range(99, 0);
    if (steady) return 0;
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(3, 1);
    if (roll < 95) return $urandom_range(10, 4);
    return $urandom_range(80, 20);
  endfunction

  function automatic void add_row(int unsigned p, int unsigned w, bit s, bit typed,
                                  longint unsigned c, longint unsigned tot);
    row_t r;
    r.item.position = POS_W'(p);
    r.item.weight = WT_W'(w);
    r.item.start_new = s;
    r.typed = typed;
    r.tally.contribution = CONTRIB_W'(c);
    r.tally.running_total = TOTAL_W'(tot);
    r.tally.saturated = 1'b0;
    directed_rows.push_back(r);
  endfunction

  // offers one word after a random gap, valid stays high when no gap follows
  task automatic send_item(input item_t it, input bit typed, input tally_t typed_tally);
    int unsigned gap;
    tally_t predicted;
    gap = pause_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {{(IN_DATA_W - POS_W - WT_W){1'b0}}, it.weight, it.position};
    in_tuser <= it.start_new;
    do @(posedge clk); while (!in_tready);
    predicted = fold_in_item(it);
    pending_tallies.push_back(typed ? typed_tally : predicted);
    words_sent++;
  endtask

  // sender stops offering until every result is back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_tallies.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // receiver: random ready with one long hold-off once the block is busy
  // ---------------------------------------------------------------------------

  initial begin : receiver
    int unsigned gap;
    bit hold_done;
    hold_done = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (!hold_done && results_seen >= HOLD_AT) begin
        // sender keeps going, so the block backs up and drops in_tready
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(12, 1)) @(posedge clk);
      gap = pause_len();
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result check against the oldest pending tally
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : result_check
    tally_t seen;
    tally_t want;
    if (rst_n && out_tvalid && out_tready) begin
      seen.contribution = out_tdata[CONTRIB_W-1:0];
      seen.running_total = out_tdata[CONTRIB_W +: TOTAL_W];
      seen.saturated = out_tuser[0];
      results_seen++;
      if (pending_tallies.size() == 0) begin
        $error("result word with nothing pending: contribution %0d running_total %0d",
               seen.contribution, seen.running_total);
        mismatches++;
      end else begin
        want = pending_tallies.pop_front();
        if (seen.contribution !== want.contribution) begin
          $error("contribution: expected %0d, got %0d", want.contribution, seen.contribution);
          mismatches++;
        end
        if (seen.running_total !== want.running_total) begin
          $error("running_total: expected %0d, got %0d",
                 want.running_total, seen.running_total);
          mismatches++;
        end
        if (seen.saturated !== want.saturated) begin
          $error("saturated: expected %0d, got %0d", want.saturated, seen.saturated);
          mismatches++;
        end
      end
    end
  end

  // hard stop, covers a hung handshake
  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("status: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    item_t       it;
    row_t        r;
    int unsigned roll;
    int unsigned len;
    int unsigned lo;
    int unsigned span;
    int unsigned wt;
    bit          mid_drained;
    mid_drained = 1'b0;

    // reset once, the block then runs its tree clearing pass behind in_tready
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed words: clamps, extremes of both fields, repeated positions,
    // start_new clearing, a short set in descending weight order
    add_row(1,       1,       0, 1, 0, 0);                    // empty trees after reset
    add_row(65536,   65536,   0, 1, 64'd4294901760, 64'd4294901760);
    add_row(0,       131071,  0, 0, 0, 0);                    // position 0 clamps to 1
    add_row(131071,  1,       0, 0, 0, 0);                    // all-ones clamps to the top
    add_row(65537,   0,       0, 0, 0, 0);                    // just past the top, zero weight
    add_row(32768,   65535,   0, 0, 0, 0);
    add_row(1,       100,     1, 1, 0, 0);                    // start_new clears everything
    add_row(1,       100,     0, 1, 0, 0);                    // same spot, zero distance
    add_row(2,       100,     0, 0, 0, 0);
    add_row(65535,   99,      0, 0, 0, 0);
    add_row(21845,   43690,   0, 0, 0, 0);
    add_row(43690,   87381,   0, 0, 0, 0);
    add_row(65536,   1,       1, 1, 0, 0);
    add_row(65536,   1,       0, 1, 0, 0);
    add_row(1,       65536,   0, 0, 0, 0);
    add_row(131071,  131071,  0, 0, 0, 0);
    add_row(0,       0,       1, 1, 0, 0);
    add_row(100000,  2,       0, 0, 0, 0);
    add_row(5,       50,      1, 1, 0, 0);
    add_row(3,       40,      0, 0, 0, 0);
    add_row(9,       30,      0, 0, 0, 0);
    add_row(7,       20,      0, 0, 0, 0);
    add_row(4,       10,      0, 0, 0, 0);
    foreach (directed_rows[k]) begin
      r = directed_rows[k];
      send_item(r.item, r.typed, r.tally);
    end
    drain_results();

    // a run of one-word sets, enough start_new words to wrap the epoch tag
    for (int k = 0; k < SINGLE_SETS; k++) begin
      it.position = POS_W'($urandom_range(65536, 1));
      it.weight = WT_W'($urandom_range(131071, 0));
      it.start_new = 1'b1;
      send_item(it, 1'b0, '0);
    end

    // random sets: mostly well-formed descending weights, with noise words
    // and now and then a set that forgets its start_new
    while (words_sent < ITEM_TARGET) begin
      if (!mid_drained && words_sent >= MID_DRAIN_AT) begin
        drain_results();
        mid_drained = 1'b1;
      end
      roll = $urandom_range(99, 0);
      if (roll < 55) len = $urandom_range(4, 1);
      else if (roll < 90) len = $urandom_range(24, 5);
      else len = $urandom_range(200, 25);
      if (len > ITEM_TARGET - words_sent) len = ITEM_TARGET - words_sent;

      // position region: full range, a tight cluster, or one of the ends
      roll = $urandom_range(99, 0);
      if (roll < 50) begin
        lo = 1;
        span = POS_COUNT;
      end else if (roll < 80) begin
        span = $urandom_range(64, 1);
        lo = $urandom_range(POS_COUNT - span + 1, 1);
      end else begin
        span = 16;
        lo = $urandom_range(1, 0) ? 1 : POS_COUNT - span + 1;
      end
      wt = $urandom_range(65536, 1);
      steady = ($urandom_range(99, 0) < 15);

      for (int k = 0; k < len; k++) begin
        it.start_new = (k == 0) && ($urandom_range(9, 0) != 0);
        if ($urandom_range(99, 0) < 8) begin
          it.position = POS_W'($urandom_range(131071, 0));
          it.weight = WT_W'($urandom_range(131071, 0));
        end else begin
          it.position = POS_W'(lo + $urandom_range(span - 1, 0));
          it.weight = WT_W'(wt);
          wt = wt - $urandom_range(wt / 8, 0);
        end
        send_item(it, 1'b0, '0);
      end
    end
    steady = 1'b0;
    in_tvalid <= 1'b0;

    // wait out the remaining results, then a little longer for strays
    while (pending_tallies.size() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
